@@ hw/rtl/i2cm_pkg.sv @@
package i2cm_pkg;

   // lanes that the word format can carry
   localparam int LANES_MAX = 4;
   localparam int LANES_DEF = 4;

   localparam logic [15:0] HALF_PERIOD_RST = 16'd50;
   localparam logic [3:0]  LANE_MASK_RST   = 4'hf;

   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_HALF_PERIOD = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LANE_MASK   = 1'd1;

   typedef enum logic [1:0] {
      CMD_TICK  = 2'd0,
      CMD_WRITE = 2'd1,
      CMD_READ  = 2'd2,
      CMD_BYTE  = 2'd3
   } cmd_type;

   typedef enum logic [3:0] {
      PH_IDLE      = 4'd0,
      PH_ST_A      = 4'd1,
      PH_ST_B      = 4'd2,
      PH_ST_C      = 4'd3,
      PH_BIT_LOW   = 4'd4,
      PH_BIT_WAIT  = 4'd5,
      PH_BIT_HIGH  = 4'd6,
      PH_ACK_LOW   = 4'd7,
      PH_ACK_WAIT  = 4'd8,
      PH_ACK_HIGH  = 4'd9,
      PH_WAIT_BYTE = 4'd10,
      PH_STOP_LOW  = 4'd11,
      PH_STOP_WAIT = 4'd12,
      PH_STOP_HIGH = 4'd13,
      PH_STOP_END  = 4'd14
   } phase_type;

   typedef struct packed {
      logic [1:0] cmd;
      logic [6:0] dev_addr;
      logic [7:0] xfer_len;
      logic [7:0] wr_byte;
      logic [3:0] scl_in;
      logic [3:0] sda_in;
   } req_item_type;

   typedef struct packed {
      logic [3:0]  scl_low;
      logic [3:0]  sda_low;
      logic        busy_res;
      logic        want_byte;
      logic        rd_valid;
      logic [31:0] rd_bytes;
      logic        ack_valid;
      logic [3:0]  addr_ack;
      logic        done_res;
      logic        cmd_refused;
   } rsp_item_type;

   // sequencer to lane cells
   typedef struct packed {
      logic shift;
      logic rd_valid;
      logic ack_valid;
   } lane_ctrl_type;

   // sequencer status for one tick
   typedef struct packed {
      logic [3:0] scl_low;
      logic [3:0] sda_low;
      logic       busy_res;
      logic       want_byte;
      logic       rd_valid;
      logic       ack_valid;
      logic       done_res;
      logic       cmd_refused;
   } seq_status_type;

endpackage

@@ hw/rtl/i2cm_lane.sv @@
module i2cm_lane
   import i2cm_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  lane_ctrl_type ctrl,
   input  logic          lane_en,
   input  logic          sda_bit,
   output logic [7:0]    rd_byte,
   output logic          ack_bit
);

   logic [7:0] rx_ff;
   logic [7:0] rx_in;
   logic       bit_v;

   // a disabled lane reads as released
   assign bit_v = sda_bit | ~lane_en;
   assign rx_in = {rx_ff[6:0], bit_v};

   always_ff @(posedge clock) begin
      if (reset) begin
         rx_ff <= '0;
      end else if (ctrl.shift) begin
         rx_ff <= rx_in;
      end
   end

   assign rd_byte = ctrl.rd_valid ? rx_in : 8'd0;
   assign ack_bit = ctrl.ack_valid & ~sda_bit & lane_en;

endmodule

@@ hw/rtl/i2cm_seq.sv @@
module i2cm_seq
   import i2cm_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           accept,
   input  req_item_type   req,
   input  logic [15:0]    half_period,
   input  logic [3:0]     lanes_on,
   output seq_status_type status,
   output lane_ctrl_type  lane_ctrl
);

   phase_type   phase_ff, phase_in;
   logic [15:0] tick_ff, tick_in;
   logic [3:0]  bit_idx_ff, bit_idx_in;
   logic [7:0]  bytes_left_ff, bytes_left_in;
   logic [7:0]  tx_ff, tx_in;
   logic [7:0]  next_byte_ff, next_byte_in;
   logic        read_mode_ff, read_mode_in;
   logic        pending_ff, pending_in;
   logic        scl_drv_ff, scl_drv_in;
   logic        sda_drv_ff, sda_drv_in;
   logic        in_addr_ff, in_addr_in;

   logic        scl_ok;
   logic [15:0] tick_plus;
   logic        elapsed;
   logic        refused;
   logic        rd_valid;
   logic        ack_valid;
   logic        done;
   logic        shift;

   assign scl_ok = (req.scl_in & lanes_on) == lanes_on;

   always_comb begin
      phase_in      = phase_ff;
      tick_in       = tick_ff;
      bit_idx_in    = bit_idx_ff;
      bytes_left_in = bytes_left_ff;
      tx_in         = tx_ff;
      next_byte_in  = next_byte_ff;
      read_mode_in  = read_mode_ff;
      pending_in    = pending_ff;
      scl_drv_in    = scl_drv_ff;
      sda_drv_in    = sda_drv_ff;
      in_addr_in    = in_addr_ff;
      refused       = 1'b0;
      rd_valid      = 1'b0;
      ack_valid     = 1'b0;
      done          = 1'b0;
      shift         = 1'b0;

      // command first
      case (req.cmd)
         CMD_WRITE, CMD_READ: begin
            if (phase_ff != PH_IDLE) begin
               refused = 1'b1;
            end else begin
               read_mode_in  = (req.cmd == CMD_READ);
               bytes_left_in = req.xfer_len;
               tx_in         = {req.dev_addr, (req.cmd == CMD_READ)};
               bit_idx_in    = '0;
               in_addr_in    = 1'b1;
               pending_in    = 1'b0;
               tick_in       = '0;
               scl_drv_in    = 1'b0;
               sda_drv_in    = 1'b0;
               phase_in      = PH_ST_A;
            end
         end
         CMD_BYTE: begin
            if (phase_ff != PH_IDLE && !read_mode_ff && !pending_ff &&
                (phase_ff == PH_WAIT_BYTE || bytes_left_ff != 8'd0)) begin
               next_byte_in = req.wr_byte;
               pending_in   = 1'b1;
            end else begin
               refused = 1'b1;
            end
         end
         default: begin
         end
      endcase

      tick_plus = tick_in + 16'd1;
      elapsed   = tick_plus >= half_period;

      // then one step of the bus machine
      case (phase_in)
         PH_IDLE: begin
         end
         PH_ST_A: begin
            tick_in = elapsed ? 16'd0 : tick_plus;
            if (elapsed) begin
               sda_drv_in = 1'b1;
               phase_in   = PH_ST_B;
            end
         end
         PH_ST_B: begin
            tick_in = elapsed ? 16'd0 : tick_plus;
            if (elapsed) begin
               scl_drv_in = 1'b1;
               phase_in   = PH_ST_C;
            end
         end
         PH_ST_C: begin
            tick_in = elapsed ? 16'd0 : tick_plus;
            if (elapsed) begin
               scl_drv_in = 1'b1;
               sda_drv_in = ~tx_in[7];
               tick_in    = '0;
               phase_in   = PH_BIT_LOW;
            end
         end
         PH_BIT_LOW: begin
            tick_in = elapsed ? 16'd0 : tick_plus;
            if (elapsed) begin
               scl_drv_in = 1'b0;
               phase_in   = PH_BIT_WAIT;
            end
         end
         PH_BIT_WAIT: begin
            if (scl_ok) begin
               if (read_mode_in && !in_addr_in) begin
                  shift    = 1'b1;
                  rd_valid = bit_idx_in >= 4'd7;
               end
               tick_in  = '0;
               phase_in = PH_BIT_HIGH;
            end
         end
         PH_BIT_HIGH: begin
            tick_in = elapsed ? 16'd0 : tick_plus;
            if (elapsed) begin
               tx_in      = {tx_in[6:0], 1'b0};
               bit_idx_in = bit_idx_in + 4'd1;
               scl_drv_in = 1'b1;
               if (bit_idx_in < 4'd8) begin
                  sda_drv_in = ~tx_in[7];
                  tick_in    = '0;
                  phase_in   = PH_BIT_LOW;
               end else begin
                  sda_drv_in = read_mode_in && !in_addr_in && bytes_left_in != 8'd0;
                  phase_in   = PH_ACK_LOW;
               end
            end
         end
         PH_ACK_LOW: begin
            tick_in = elapsed ? 16'd0 : tick_plus;
            if (elapsed) begin
               scl_drv_in = 1'b0;
               phase_in   = PH_ACK_WAIT;
            end
         end
         PH_ACK_WAIT: begin
            if (scl_ok) begin
               ack_valid = read_mode_in && in_addr_in;
               tick_in   = '0;
               phase_in  = PH_ACK_HIGH;
            end
         end
         PH_ACK_HIGH: begin
            tick_in = elapsed ? 16'd0 : tick_plus;
            if (elapsed) begin
               scl_drv_in = 1'b1;
               if (bytes_left_in == 8'd0) begin
                  sda_drv_in = 1'b1;
                  phase_in   = PH_STOP_LOW;
               end else begin
                  bytes_left_in = bytes_left_in - 8'd1;
                  in_addr_in    = 1'b0;
                  bit_idx_in    = '0;
                  if (read_mode_in) begin
                     tx_in      = 8'hff;
                     sda_drv_in = 1'b0;
                     tick_in    = '0;
                     phase_in   = PH_BIT_LOW;
                  end else if (pending_in) begin
                     tx_in      = next_byte_in;
                     pending_in = 1'b0;
                     sda_drv_in = ~next_byte_in[7];
                     tick_in    = '0;
                     phase_in   = PH_BIT_LOW;
                  end else begin
                     sda_drv_in = 1'b0;
                     phase_in   = PH_WAIT_BYTE;
                  end
               end
            end
         end
         PH_WAIT_BYTE: begin
            if (pending_in) begin
               tx_in      = next_byte_in;
               pending_in = 1'b0;
               scl_drv_in = 1'b1;
               sda_drv_in = ~next_byte_in[7];
               tick_in    = '0;
               phase_in   = PH_BIT_LOW;
            end
         end
         PH_STOP_LOW: begin
            tick_in = elapsed ? 16'd0 : tick_plus;
            if (elapsed) begin
               scl_drv_in = 1'b0;
               phase_in   = PH_STOP_WAIT;
            end
         end
         PH_STOP_WAIT: begin
            if (scl_ok) begin
               tick_in  = '0;
               phase_in = PH_STOP_HIGH;
            end
         end
         PH_STOP_HIGH: begin
            tick_in = elapsed ? 16'd0 : tick_plus;
            if (elapsed) begin
               sda_drv_in = 1'b0;
               phase_in   = PH_STOP_END;
            end
         end
         PH_STOP_END: begin
            tick_in = elapsed ? 16'd0 : tick_plus;
            if (elapsed) begin
               done     = 1'b1;
               phase_in = PH_IDLE;
            end
         end
         default: begin
            phase_in   = PH_IDLE;
            scl_drv_in = 1'b0;
            sda_drv_in = 1'b0;
            tick_in    = '0;
         end
      endcase
   end

   always_comb begin
      status.scl_low     = scl_drv_in ? lanes_on : 4'd0;
      status.sda_low     = sda_drv_in ? lanes_on : 4'd0;
      status.busy_res    = phase_in != PH_IDLE;
      status.want_byte   = phase_in == PH_WAIT_BYTE;
      status.rd_valid    = rd_valid;
      status.ack_valid   = ack_valid;
      status.done_res    = done;
      status.cmd_refused = refused;
      lane_ctrl.shift     = accept & shift;
      lane_ctrl.rd_valid  = rd_valid;
      lane_ctrl.ack_valid = ack_valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         tick_ff       <= '0;
         bit_idx_ff    <= '0;
         bytes_left_ff <= '0;
         tx_ff         <= '0;
         next_byte_ff  <= '0;
         read_mode_ff  <= 1'b0;
         pending_ff    <= 1'b0;
         scl_drv_ff    <= 1'b0;
         sda_drv_ff    <= 1'b0;
         in_addr_ff    <= 1'b0;
      end else if (accept) begin
         phase_ff      <= phase_in;
         tick_ff       <= tick_in;
         bit_idx_ff    <= bit_idx_in;
         bytes_left_ff <= bytes_left_in;
         tx_ff         <= tx_in;
         next_byte_ff  <= next_byte_in;
         read_mode_ff  <= read_mode_in;
         pending_ff    <= pending_in;
         scl_drv_ff    <= scl_drv_in;
         sda_drv_ff    <= sda_drv_in;
         in_addr_ff    <= in_addr_in;
      end
   end

endmodule

@@ hw/rtl/i2cm_merge.sv @@
module i2cm_merge
   import i2cm_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   input  seq_status_type               status,
   input  logic [LANES_MAX-1:0][7:0]    rd_lanes,
   input  logic [LANES_MAX-1:0]         ack_lanes,
   input  logic                         rsp_stall,
   output logic                         rsp_valid,
   output rsp_item_type                 rsp_data,
   output logic                         req_stall
);

   rsp_item_type item;
   rsp_item_type out_ff, skid_ff;
   logic         out_valid_ff, skid_valid_ff;
   logic         pop;

   always_comb begin
      item.scl_low     = status.scl_low;
      item.sda_low     = status.sda_low;
      item.busy_res    = status.busy_res;
      item.want_byte   = status.want_byte;
      item.rd_valid    = status.rd_valid;
      item.rd_bytes    = rd_lanes;
      item.ack_valid   = status.ack_valid;
      item.addr_ack    = ack_lanes;
      item.done_res    = status.done_res;
      item.cmd_refused = status.cmd_refused;
   end

   assign pop = out_valid_ff & ~rsp_stall;

   // output register plus skid word
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (pop) begin
         if (skid_valid_ff) begin
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff <= push;
         end
      end else if (push) begin
         if (out_valid_ff) begin
            skid_valid_ff <= 1'b1;
         end else begin
            out_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop && skid_valid_ff) begin
         out_ff <= skid_ff;
      end else if (push && (pop || !out_valid_ff)) begin
         out_ff <= item;
      end
      if (push && out_valid_ff && !pop) begin
         skid_ff <= item;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;
   assign req_stall = skid_valid_ff;

endmodule

@@ hw/rtl/multi_lane_i2c_master.sv @@
// multi-lane i2c master: drives up to four i2c buses in lockstep from one
// sequencer. each request word is one timer tick carrying the sampled scl and
// sda levels of every lane plus an optional command (begin write, begin read,
// supply write byte); each tick gives exactly one response word with the
// lanes to pull low and the status of that tick. a word is taken every clock
// cycle: the sequencer advances one tick per accepted word, the lane cells
// shift their received bits in the same cycle, and the response goes through
// an output register backed by a skid word, so req_stall rises only when
// both hold words that the consumer has not yet taken. configuration writes
// (half period, lane mask) are always ready and must be made while no
// transfer is running
module multi_lane_i2c_master
   import i2cm_pkg::*;
#(
   parameter int LANES = LANES_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   // request channel, one word per timer tick
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_item_type          req_data,
   // response channel
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_item_type          rsp_data,
   // configuration writes
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   // lanes past four do not fit the word format and are not built
   localparam int LANES_USED = (LANES < LANES_MAX) ? LANES : LANES_MAX;
   localparam logic [LANES_MAX-1:0] LANE_ALL =
      LANES_MAX'((1 << LANES_USED) - 1);

   logic [15:0] half_period_ff;
   logic [3:0]  lane_mask_ff;
   logic [3:0]  lanes_on;
   logic        accept;

   seq_status_type              status;
   lane_ctrl_type               lane_ctrl;
   logic [LANES_MAX-1:0][7:0]   rd_lanes;
   logic [LANES_MAX-1:0]        ack_lanes;

   assign csr_ready = 1'b1;

   // register file
   always_ff @(posedge clock) begin
      if (reset) begin
         half_period_ff <= HALF_PERIOD_RST;
         lane_mask_ff   <= LANE_MASK_RST;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_HALF_PERIOD: half_period_ff <= csr_wdata;
            CSR_LANE_MASK:   lane_mask_ff   <= csr_wdata[3:0];
            default: begin
            end
         endcase
      end
   end

   // only lanes that exist can be enabled
   assign lanes_on = lane_mask_ff & LANE_ALL;
   assign accept   = req_valid & ~req_stall;

   // shared bus sequencer: phases, bit timing, clock stretching wait
   i2cm_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .req         (req_data),
      .half_period (half_period_ff),
      .lanes_on    (lanes_on),
      .status      (status),
      .lane_ctrl   (lane_ctrl)
   );

   // one receive cell per lane, absent lanes read as zero
   for (genvar g = 0; g < LANES_MAX; g++) begin : g_lane
      if (g < LANES_USED) begin : g_on
         i2cm_lane u_lane (
            .clock   (clock),
            .reset   (reset),
            .ctrl    (lane_ctrl),
            .lane_en (lanes_on[g]),
            .sda_bit (req_data.sda_in[g]),
            .rd_byte (rd_lanes[g]),
            .ack_bit (ack_lanes[g])
         );
      end else begin : g_off
         assign rd_lanes[g]  = 8'd0;
         assign ack_lanes[g] = 1'b0;
      end
   end

   // gather lane results into the response word and buffer it
   i2cm_merge u_merge (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .status    (status),
      .rd_lanes  (rd_lanes),
      .ack_lanes (ack_lanes),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .req_stall (req_stall)
   );

endmodule

@@ tb/sv/multi_lane_i2c_master_checker.sv @@
`timescale 1ns / 1ps

module multi_lane_i2c_master_checker
   import i2cm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  req_item_type          req_data,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  rsp_item_type          rsp_data,
   input  logic                  csr_valid,
   input  logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    mismatch_count,
   output int                    words_in_flight
);

   // configuration copy
   logic [15:0] half_period;
   logic [3:0]  lane_en;

   // bus sequencer copy
   phase_type   phase;
   logic [15:0] tick_cnt;
   logic [3:0]  bit_idx;
   logic [7:0]  bytes_left;
   logic [7:0]  tx_byte;
   logic [7:0]  rx_byte [4];
   logic [7:0]  held_byte;
   bit          reading;
   bit          byte_held;
   bit          scl_pull;
   bit          sda_pull;
   bit          addr_stage;

   rsp_item_type expected_words [$];
   int errs = 0;

   function automatic void clear_bus_state();
      half_period = HALF_PERIOD_RST;
      lane_en     = LANE_MASK_RST;
      phase       = PH_IDLE;
      tick_cnt    = '0;
      bit_idx     = '0;
      bytes_left  = '0;
      tx_byte     = '0;
      held_byte   = '0;
      reading     = 1'b0;
      byte_held   = 1'b0;
      scl_pull    = 1'b0;
      sda_pull    = 1'b0;
      addr_stage  = 1'b0;
      for (int i = 0; i < 4; i++) rx_byte[i] = '0;
   endfunction

   // counts one tick, true once the half period has run out
   function automatic bit half_period_up();
      tick_cnt = tick_cnt + 16'd1;
      if (tick_cnt >= half_period) begin
         tick_cnt = '0;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic void drive_bit();
      scl_pull = 1'b1;
      sda_pull = !tx_byte[7];
      tick_cnt = '0;
      phase    = PH_BIT_LOW;
   endfunction

   function automatic rsp_item_type bus_tick(input req_item_type w);
      rsp_item_type r;
      logic [3:0]   m;
      logic [3:0]   sda_seen;
      bit           clk_free;
      r        = '0;
      m        = lane_en;
      sda_seen = w.sda_in | ~m;
      clk_free = (w.scl_in & m) == m;

      case (cmd_type'(w.cmd))
         CMD_WRITE, CMD_READ: begin
            if (phase != PH_IDLE) begin
               r.cmd_refused = 1'b1;
            end else begin
               reading    = (w.cmd == CMD_READ);
               bytes_left = w.xfer_len;
               tx_byte    = {w.dev_addr, reading};
               bit_idx    = '0;
               addr_stage = 1'b1;
               byte_held  = 1'b0;
               tick_cnt   = '0;
               scl_pull   = 1'b0;
               sda_pull   = 1'b0;
               phase      = PH_ST_A;
            end
         end
         CMD_BYTE: begin
            if (phase != PH_IDLE && !reading && !byte_held &&
                (phase == PH_WAIT_BYTE || bytes_left != 0)) begin
               held_byte = w.wr_byte;
               byte_held = 1'b1;
            end else begin
               r.cmd_refused = 1'b1;
            end
         end
         default: ;
      endcase

      case (phase)
         PH_IDLE: ;
         PH_ST_A: if (half_period_up()) begin
            sda_pull = 1'b1;
            phase    = PH_ST_B;
         end
         PH_ST_B: if (half_period_up()) begin
            scl_pull = 1'b1;
            phase    = PH_ST_C;
         end
         PH_ST_C: if (half_period_up()) drive_bit();
         PH_BIT_LOW: if (half_period_up()) begin
            scl_pull = 1'b0;
            phase    = PH_BIT_WAIT;
         end
         PH_BIT_WAIT: if (clk_free) begin
            if (reading && !addr_stage) begin
               for (int i = 0; i < 4; i++) rx_byte[i] = {rx_byte[i][6:0], sda_seen[i]};
               if (bit_idx >= 4'd7) begin
                  r.rd_valid = 1'b1;
                  r.rd_bytes = {rx_byte[3], rx_byte[2], rx_byte[1], rx_byte[0]};
               end
            end
            tick_cnt = '0;
            phase    = PH_BIT_HIGH;
         end
         PH_BIT_HIGH: if (half_period_up()) begin
            tx_byte = tx_byte << 1;
            bit_idx = bit_idx + 4'd1;
            if (bit_idx < 4'd8) begin
               drive_bit();
            end else begin
               scl_pull = 1'b1;
               sda_pull = reading && !addr_stage && bytes_left != 0;
               phase    = PH_ACK_LOW;
            end
         end
         PH_ACK_LOW: if (half_period_up()) begin
            scl_pull = 1'b0;
            phase    = PH_ACK_WAIT;
         end
         PH_ACK_WAIT: if (clk_free) begin
            if (reading && addr_stage) begin
               r.ack_valid = 1'b1;
               r.addr_ack  = ~w.sda_in & m;
            end
            tick_cnt = '0;
            phase    = PH_ACK_HIGH;
         end
         PH_ACK_HIGH: if (half_period_up()) begin
            scl_pull = 1'b1;
            if (bytes_left == 0) begin
               sda_pull = 1'b1;
               phase    = PH_STOP_LOW;
            end else begin
               bytes_left = bytes_left - 8'd1;
               addr_stage = 1'b0;
               bit_idx    = '0;
               if (reading) begin
                  tx_byte = 8'hff;
                  drive_bit();
               end else if (byte_held) begin
                  tx_byte   = held_byte;
                  byte_held = 1'b0;
                  drive_bit();
               end else begin
                  sda_pull = 1'b0;
                  phase    = PH_WAIT_BYTE;
               end
            end
         end
         PH_WAIT_BYTE: if (byte_held) begin
            tx_byte   = held_byte;
            byte_held = 1'b0;
            drive_bit();
         end
         PH_STOP_LOW: if (half_period_up()) begin
            scl_pull = 1'b0;
            phase    = PH_STOP_WAIT;
         end
         PH_STOP_WAIT: if (clk_free) begin
            tick_cnt = '0;
            phase    = PH_STOP_HIGH;
         end
         PH_STOP_HIGH: if (half_period_up()) begin
            sda_pull = 1'b0;
            phase    = PH_STOP_END;
         end
         PH_STOP_END: if (half_period_up()) begin
            r.done_res = 1'b1;
            phase      = PH_IDLE;
         end
         default: begin
            phase    = PH_IDLE;
            scl_pull = 1'b0;
            sda_pull = 1'b0;
            tick_cnt = '0;
         end
      endcase

      r.scl_low   = scl_pull ? m : 4'h0;
      r.sda_low   = sda_pull ? m : 4'h0;
      r.busy_res  = phase != PH_IDLE;
      r.want_byte = phase == PH_WAIT_BYTE;
      return r;
   endfunction

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         errs++;
         $display("%0t ns: %s expected %0h, got %0h", $time, name, want, got);
      end
   endtask

   task automatic check_word(input rsp_item_type want, input rsp_item_type got);
      check_field("scl_low", want.scl_low, got.scl_low);
      check_field("sda_low", want.sda_low, got.sda_low);
      check_field("busy_res", want.busy_res, got.busy_res);
      check_field("want_byte", want.want_byte, got.want_byte);
      check_field("rd_valid", want.rd_valid, got.rd_valid);
      check_field("rd_bytes", want.rd_bytes, got.rd_bytes);
      check_field("ack_valid", want.ack_valid, got.ack_valid);
      check_field("addr_ack", want.addr_ack, got.addr_ack);
      check_field("done_res", want.done_res, got.done_res);
      check_field("cmd_refused", want.cmd_refused, got.cmd_refused);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_bus_state();
         expected_words.delete();
         words_in_flight <= 0;
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_HALF_PERIOD) half_period = csr_wdata;
            else if (csr_index == CSR_LANE_MASK) lane_en = csr_wdata[3:0];
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_words.size() == 0) begin
               errs++;
               $display("%0t ns: response word with none expected, expected nothing, got %0h",
                        $time, rsp_data);
            end else begin
               check_word(expected_words.pop_front(), rsp_data);
            end
         end
         if (req_valid && !req_stall) expected_words.push_back(bus_tick(req_data));
         words_in_flight <= expected_words.size();
      end
      mismatch_count <= errs;
   end

endmodule

@@ tb/sv/multi_lane_i2c_master_tb.sv @@
`timescale 1ns / 1ps

module multi_lane_i2c_master_tb;
   import i2cm_pkg::*;

   // cycles with no word moving on any channel before the run is abandoned
   localparam int QUIET_LIMIT  = 2000;
   // request words in the randomised part
   localparam int RANDOM_WORDS = 250;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_item_type          req_data  = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_item_type          rsp_data;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_HALF_PERIOD;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   int mismatch_count;
   int words_in_flight;

   // idling behaviour: 0 none, 1 occasional gaps, 2 a gap drawn for every word
   int send_mode  = 0;
   int recv_mode  = 0;
   int stall_left = 0;
   int rsp_gap    = 0;
   int quiet      = 0;

   // what the response side has seen, used to pace the stimulus
   int   sent_words       = 0;
   int   closed_transfers = 0;
   int   read_words       = 0;
   int   refusals         = 0;
   logic last_busy        = 1'b0;

   always #5 clock = ~clock;

   multi_lane_i2c_master uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   multi_lane_i2c_master_checker bus_check (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_data        (req_data),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_data        (rsp_data),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .mismatch_count  (mismatch_count),
      .words_in_flight (words_in_flight)
   );

   function automatic int draw_wait(input int mode);
      case (mode)
         0:       return 0;
         1:       return ($urandom_range(0, 5) == 0) ? $urandom_range(1, 14) : 0;
         default: return $urandom_range(0, 14);
      endcase
   endfunction

   // consumer side: after each word taken, stall for a drawn number of cycles,
   // and keep track of transfer completions and of whether the bus is busy
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else if (rsp_valid && !rsp_stall) begin
         rsp_gap           = draw_wait(recv_mode);
         stall_left       <= rsp_gap;
         rsp_stall        <= (rsp_gap != 0) ? 1'b1 : 1'b0;
         closed_transfers <= closed_transfers + rsp_data.done_res;
         read_words       <= read_words + rsp_data.rd_valid;
         refusals         <= refusals + rsp_data.cmd_refused;
         last_busy        <= rsp_data.busy_res;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         if (stall_left == 1) rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // watchdog on channel activity
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet <= 0;
      end else if (quiet == QUIET_LIMIT) begin
         $display("%0t ns: no word moved for %0d cycles", $time, QUIET_LIMIT);
         $display("Test completed with failures");
         $finish;
      end else begin
         quiet <= quiet + 1;
      end
   end

   // one timer tick with pin samples: scl released on every lane except when
   // some target stretches the clock, sda whatever the targets drive
   function automatic req_item_type bus_word(input cmd_type op);
      req_item_type w;
      w.cmd      = op;
      w.dev_addr = 7'($urandom);
      w.xfer_len = 8'($urandom);
      w.wr_byte  = 8'($urandom);
      w.sda_in   = 4'($urandom);
      w.scl_in   = ($urandom_range(0, 5) == 0) ? 4'($urandom) : 4'hf;
      return w;
   endfunction

   // valid stays high across back-to-back words, so it is only lowered for a gap
   task automatic send_word(input req_item_type w);
      int gap;
      gap = draw_wait(send_mode);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      do @(posedge clock); while (req_stall);
      sent_words++;
   endtask

   // stop sending and wait for every outstanding response word
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (words_in_flight != 0);
   endtask

   // run the bus on until the block reports idle, feeding bytes to any write
   task automatic settle();
      drain();
      while (last_busy) begin
         for (int i = 0; i < 8; i++)
            send_word(bus_word(($urandom_range(0, 3) == 0) ? CMD_BYTE : CMD_TICK));
         drain();
      end
   endtask

   // both registers in one go, valid held high between the two words
   task automatic configure(input logic [15:0] half_period, input logic [3:0] lanes);
      csr_valid <= 1'b1;
      csr_index <= CSR_HALF_PERIOD;
      csr_wdata <= half_period;
      do @(posedge clock); while (!csr_ready);
      csr_index <= CSR_LANE_MASK;
      csr_wdata <= {12'h000, lanes};
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // one complete transfer; early on, a begin is thrown in while the bus is
   // certainly busy, and writes get their payload bytes at random ticks
   task automatic run_transfer(input cmd_type op, input logic [6:0] addr,
                               input logic [7:0] len);
      req_item_type w;
      int           start_done;
      int           k;
      settle();
      start_done = closed_transfers;
      w          = bus_word(op);
      w.dev_addr = addr;
      w.xfer_len = len;
      w.scl_in   = 4'hf;
      send_word(w);
      k = 0;
      while (closed_transfers == start_done) begin
         k++;
         if (k < 20 && $urandom_range(0, 7) == 0)
            w = bus_word(($urandom_range(0, 1) == 0) ? CMD_WRITE : CMD_READ);
         else if (op == CMD_WRITE)
            w = bus_word(($urandom_range(0, 4) == 0) ? CMD_BYTE : CMD_TICK);
         else
            w = bus_word(($urandom_range(0, 29) == 0) ? CMD_BYTE : CMD_TICK);
         send_word(w);
      end
   endtask

   // unstructured words: any command, arbitrary pin levels, short lengths so
   // that a transfer started here finishes quickly
   task automatic noise_burst();
      req_item_type w;
      int           n;
      n = $urandom_range(4, 16);
      for (int i = 0; i < n; i++) begin
         w          = bus_word(cmd_type'($urandom_range(0, 3)));
         w.xfer_len = 8'($urandom_range(0, 2));
         w.scl_in   = 4'($urandom);
         send_word(w);
      end
      settle();
   endtask

   function automatic logic [15:0] pick_half_period();
      int r;
      r = $urandom_range(0, 19);
      if (r == 0) return 16'd0;
      if (r < 3) return 16'($urandom_range(4, 8));
      if (r < 8) return 16'($urandom_range(2, 3));
      return 16'd1;
   endfunction

   initial begin
      int directed_words;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // reset settings: idle ticks and a byte offered with nothing to write
      send_mode = 1;
      recv_mode <= 1;
      send_word(bus_word(CMD_TICK));
      send_word(bus_word(CMD_BYTE));

      // fastest bus on all lanes: a short write and an address-only read
      settle();
      configure(16'd1, 4'hf);
      run_transfer(CMD_WRITE, 7'h7f, 8'd2);
      run_transfer(CMD_READ, 7'h00, 8'd0);

      // zero half period and no lanes enabled
      settle();
      configure(16'd0, 4'h0);
      run_transfer(CMD_READ, 7'h11, 8'd1);
      run_transfer(CMD_WRITE, 7'h22, 8'd1);

      // single lane with heavy idling on both sides
      settle();
      configure(16'd1, 4'h1);
      send_mode = 2;
      recv_mode <= 2;
      run_transfer(CMD_READ, 7'h3c, 8'd1);
      run_transfer(CMD_WRITE, 7'h43, 8'd1);

      // slowest bus: only idle ticks and refused bytes, a transfer would never end
      settle();
      configure(16'hffff, 4'hf);
      for (int i = 0; i < 6; i++) send_word(bus_word((i % 2) ? CMD_BYTE : CMD_TICK));

      // multi-byte read on alternate lanes, back to back with no stalls
      settle();
      configure(16'd1, 4'ha);
      send_mode = 0;
      recv_mode <= 0;
      run_transfer(CMD_READ, 7'h5a, 8'd3);
      directed_words = sent_words;

      // randomised part: mostly well-formed transfers of a few bytes, with
      // the occasional noise burst and new bus settings between transfers
      while (sent_words < directed_words + RANDOM_WORDS) begin
         if ($urandom_range(0, 3) == 0) begin
            settle();
            configure(pick_half_period(),
                      ($urandom_range(0, 19) == 0) ? 4'h0 : 4'($urandom_range(1, 15)));
         end
         send_mode = $urandom_range(0, 2);
         recv_mode <= $urandom_range(0, 2);
         if ($urandom_range(0, 6) == 0)
            noise_burst();
         else
            run_transfer(($urandom_range(0, 1) == 0) ? CMD_WRITE : CMD_READ, 7'($urandom),
                         ($urandom_range(0, 9) == 0) ? 8'($urandom_range(4, 8))
                                                     : 8'($urandom_range(0, 3)));
      end

      settle();
      repeat (20) @(posedge clock);

      $display("run covered %0d request words, %0d finished transfers,", sent_words,
               closed_transfers);
      $display("%0d read words, %0d refused commands, half periods from zero to the slowest",
               read_words, refusals);
      $display("lane sets from none to all, with clock stretching and idling on both sides");
      if (mismatch_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
